@@ rtl/psvlq_pkg.sv @@
// Package with the shared types and constants of the primitive serializer.
`timescale 1ns / 1ps

package psvlq_pkg;

   // Width of the running stream position and of the value field.
   localparam int unsigned POS_W = 64;
   // Width of the reported position.
   localparam int unsigned OUT_POS_W = 63;
   // Staging register: ten 7-bit groups hold any 64-bit value.
   localparam int unsigned SR_W = 70;
   // Width of the alignment modulus field.
   localparam int unsigned MOD_W = 7;
   // Width of the per-item byte counter.
   localparam int unsigned CNT_W = 7;
   // Varint group count of a full 64-bit value.
   localparam logic [CNT_W-1:0] VLQ_MAX_GROUPS = 7'd10;
   localparam logic [6:0] GROUP_MASK = 7'h7f;
   localparam logic [7:0] CONT_BIT = 8'h80;

   typedef enum logic [2:0] {
      KIND_BYTE  = 3'd0,
      KIND_U32   = 3'd1,
      KIND_U64   = 3'd2,
      KIND_C32   = 3'd3,
      KIND_C64   = 3'd4,
      KIND_ALIGN = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      MODE_BE,
      MODE_VLQ,
      MODE_PAD
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NORM,
      ST_REM,
      ST_EMIT
   } state_type;

   // Command to the remainder unit.
   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] dividend;
      logic [MOD_W-1:0] modulus;
   } rem_cmd_type;

   // Status from the remainder unit.
   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] rem;
   } rem_sts_type;

endpackage

@@ rtl/primitive_serializer_vlq.sv @@
// Top level of the primitive serializer with base-128 varint encoding.
`timescale 1ns / 1ps

// The request channel (req_) takes one primitive per beat: a kind code, a
// 64-bit value and an alignment modulus. The response channel (rsp_) gives
// one stream byte per beat, with a flag on the last byte of the item and the
// low 63 bits of the stream byte count after that byte.
// The block handles one item at a time and drops req_ready until the last
// byte of the item has been loaded into the output register.
// Fixed-width kinds (byte, u32, u64) send 1, 4 or 8 bytes, one byte per
// cycle while the receiver takes them.
// Varint kinds first normalize the value in a 70-bit shift register, one
// 7-bit group per cycle (up to 9 shifts), then send one group per cycle
// while the receiver takes them.
// Alignment runs a bit-serial remainder of the 64-bit position, then sends
// one zero pad byte per cycle while the receiver takes them. Unused kinds,
// a modulus below two and an already aligned position send nothing.
// The fixed-width and varint kinds share one shifter.
// Reset clears the stream position, the control state and rsp_valid; a held beat is lost.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits with it; nothing is skipped or repeated.

module primitive_serializer_vlq #(
   parameter int unsigned MAX_ALIGN = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_kind,
   input  logic [psvlq_pkg::POS_W-1:0]         req_value,
   input  logic [psvlq_pkg::MOD_W-1:0]         req_align_modulus,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last,
   output logic [psvlq_pkg::OUT_POS_W-1:0]     rsp_position
);

   localparam int unsigned SR_W = psvlq_pkg::SR_W;

   psvlq_pkg::state_type state_ff, state_in;
   psvlq_pkg::mode_type  mode_ff, mode_in;

   logic [SR_W-1:0]                 sr_ff, sr_in;
   logic [psvlq_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [psvlq_pkg::MOD_W-1:0]     mod_ff, mod_in;
   logic [psvlq_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      byte_ff, byte_in;
   logic                            last_ff, last_in;
   logic [psvlq_pkg::OUT_POS_W-1:0] opos_ff, opos_in;

   logic                            accept;
   logic                            slot_free;
   logic                            emit;
   logic [psvlq_pkg::MOD_W-1:0]     eff_mod;
   logic                            trivial_mod;
   logic                            norm_step;
   logic [SR_W-1:0]                 sr_shifted;
   logic [psvlq_pkg::CNT_W-1:0]     fill;

   psvlq_pkg::rem_cmd_type rem_cmd;
   psvlq_pkg::rem_sts_type rem_sts;

   psvlq_rem u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .sts   (rem_sts)
   );

   // A modulus above MAX_ALIGN is clamped to it.
   always_comb begin
      if ({25'd0, req_align_modulus} > MAX_ALIGN) begin
         eff_mod = psvlq_pkg::MOD_W'(MAX_ALIGN);
      end else begin
         eff_mod = req_align_modulus;
      end
      trivial_mod = (eff_mod < psvlq_pkg::MOD_W'(2));
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign fill      = psvlq_pkg::CNT_W'(mod_ff - rem_sts.rem);

   // Leading all-zero groups are dropped, but one group always remains.
   assign norm_step = (sr_ff[SR_W-1 -: 7] == 7'd0) && (cnt_ff > psvlq_pkg::CNT_W'(1));

   // The one shifter: by a varint group or by a byte.
   always_comb begin
      if (mode_ff == psvlq_pkg::MODE_BE) begin
         sr_shifted = {sr_ff[SR_W-9:0], 8'd0};
      end else begin
         sr_shifted = {sr_ff[SR_W-8:0], 7'd0};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psvlq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind) inside
                  psvlq_pkg::KIND_BYTE, psvlq_pkg::KIND_U32, psvlq_pkg::KIND_U64: begin
                     state_in = psvlq_pkg::ST_EMIT;
                  end
                  psvlq_pkg::KIND_C32, psvlq_pkg::KIND_C64: begin
                     state_in = psvlq_pkg::ST_NORM;
                  end
                  psvlq_pkg::KIND_ALIGN: begin
                     if (!trivial_mod) begin
                        state_in = psvlq_pkg::ST_REM;
                     end
                  end
                  default: begin
                     state_in = psvlq_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         psvlq_pkg::ST_NORM: begin
            if (!norm_step) begin
               state_in = psvlq_pkg::ST_EMIT;
            end
         end
         psvlq_pkg::ST_REM: begin
            if (rem_sts.done) begin
               if (rem_sts.rem == '0) begin
                  state_in = psvlq_pkg::ST_IDLE;
               end else begin
                  state_in = psvlq_pkg::ST_EMIT;
               end
            end
         end
         psvlq_pkg::ST_EMIT: begin
            if (slot_free && (cnt_ff == psvlq_pkg::CNT_W'(1))) begin
               state_in = psvlq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psvlq_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready        = 1'b0;
      emit             = 1'b0;
      rem_cmd.start    = 1'b0;
      rem_cmd.dividend = pos_ff;
      rem_cmd.modulus  = eff_mod;
      unique case (state_ff)
         psvlq_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            rem_cmd.start = req_valid && (req_kind == psvlq_pkg::KIND_ALIGN) && !trivial_mod;
         end
         psvlq_pkg::ST_NORM: begin
         end
         psvlq_pkg::ST_REM: begin
         end
         psvlq_pkg::ST_EMIT: begin
            emit = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath.
   always_comb begin
      sr_in        = sr_ff;
      cnt_in       = cnt_ff;
      mod_in       = mod_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      opos_in      = opos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         mod_in = eff_mod;
         case (req_kind)
            psvlq_pkg::KIND_BYTE: begin
               sr_in   = {req_value[7:0], 62'd0};
               cnt_in  = psvlq_pkg::CNT_W'(1);
               mode_in = psvlq_pkg::MODE_BE;
            end
            psvlq_pkg::KIND_U32: begin
               sr_in   = {req_value[31:0], 38'd0};
               cnt_in  = psvlq_pkg::CNT_W'(4);
               mode_in = psvlq_pkg::MODE_BE;
            end
            psvlq_pkg::KIND_U64: begin
               sr_in   = {req_value, 6'd0};
               cnt_in  = psvlq_pkg::CNT_W'(8);
               mode_in = psvlq_pkg::MODE_BE;
            end
            psvlq_pkg::KIND_C32: begin
               sr_in   = {38'd0, req_value[31:0]};
               cnt_in  = psvlq_pkg::VLQ_MAX_GROUPS;
               mode_in = psvlq_pkg::MODE_VLQ;
            end
            psvlq_pkg::KIND_C64: begin
               sr_in   = {6'd0, req_value};
               cnt_in  = psvlq_pkg::VLQ_MAX_GROUPS;
               mode_in = psvlq_pkg::MODE_VLQ;
            end
            default: begin
               mode_in = psvlq_pkg::MODE_PAD;
            end
         endcase
      end

      if ((state_ff == psvlq_pkg::ST_NORM) && norm_step) begin
         sr_in  = sr_shifted;
         cnt_in = cnt_ff - psvlq_pkg::CNT_W'(1);
      end

      if ((state_ff == psvlq_pkg::ST_REM) && rem_sts.done) begin
         cnt_in  = fill;
         mode_in = psvlq_pkg::MODE_PAD;
      end

      if (emit) begin
         case (mode_ff)
            psvlq_pkg::MODE_BE: begin
               byte_in = sr_ff[SR_W-1 -: 8];
            end
            psvlq_pkg::MODE_VLQ: begin
               byte_in = {1'b0, sr_ff[SR_W-1 -: 7] & psvlq_pkg::GROUP_MASK};
               if (cnt_ff != psvlq_pkg::CNT_W'(1)) begin
                  byte_in = byte_in | psvlq_pkg::CONT_BIT;
               end
            end
            default: begin
               byte_in = 8'd0;
            end
         endcase
         last_in      = (cnt_ff == psvlq_pkg::CNT_W'(1));
         pos_in       = pos_ff + psvlq_pkg::POS_W'(1);
         opos_in      = pos_in[psvlq_pkg::OUT_POS_W-1:0];
         rsp_valid_in = 1'b1;
         sr_in        = sr_shifted;
         cnt_in       = cnt_ff - psvlq_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      sr_ff   <= sr_in;
      cnt_ff  <= cnt_in;
      mod_ff  <= mod_in;
      mode_ff <= mode_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      opos_ff <= opos_in;
      if (reset) begin
         state_ff     <= psvlq_pkg::ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_position = opos_ff;

endmodule

@@ rtl/psvlq_rem.sv @@
// Bit-serial remainder unit: stream position modulo a small modulus.
`timescale 1ns / 1ps

module psvlq_rem (
   input  logic                   clock,
   input  logic                   reset,
   input  psvlq_pkg::rem_cmd_type cmd,
   output psvlq_pkg::rem_sts_type sts
);

   localparam int unsigned STEP_W = $clog2(psvlq_pkg::POS_W);

   logic [psvlq_pkg::POS_W-1:0] div_ff, div_in;
   logic [psvlq_pkg::MOD_W-1:0] mod_ff, mod_in;
   logic [psvlq_pkg::MOD_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [psvlq_pkg::MOD_W:0]   trial;

   // One dividend bit per cycle, restoring style.
   always_comb begin
      trial   = {rem_ff, div_ff[psvlq_pkg::POS_W-1]};
      div_in  = div_ff;
      mod_in  = mod_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         div_in  = cmd.dividend;
         mod_in  = cmd.modulus;
         rem_in  = '0;
         step_in = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         div_in = {div_ff[psvlq_pkg::POS_W-2:0], 1'b0};
         if (trial >= {1'b0, mod_ff}) begin
            rem_in = psvlq_pkg::MOD_W'(trial - {1'b0, mod_ff});
         end else begin
            rem_in = trial[psvlq_pkg::MOD_W-1:0];
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      mod_ff  <= mod_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done = done_ff;
   assign sts.rem  = rem_ff;

endmodule

@@ tb/tb_primitive_serializer_vlq.sv @@
// Testbench for the primitive serializer: directed table, random items, beat-by-beat checks.
`timescale 1ns / 1ps

// The bench drives the request channel from one process and the response
// ready from another, each with its own random gaps, and watches both
// channels from a single monitor that runs on the rising edge.
//
// When a request beat is accepted, the monitor computes the bytes it must
// cause and appends them to a queue of expected stream beats. The running
// stream count lives in the bench so that every expected beat carries its
// position. Each response beat is compared with the head of that queue.
//
// The directed table covers the extremes of each kind, the unused kinds,
// the trivial, oversized and already aligned modulus cases, and varint
// boundaries. Rows whose bytes are obvious carry them typed in. The other
// rows, and all random items, go through the predictor.

module tb_primitive_serializer_vlq;

   localparam int unsigned ALIGN_LIMIT = 64;
   // Random items after the directed table, unused kinds included.
   localparam int RANDOM_ITEMS = 235;
   // Cycles with no accepted beat on either channel before the run is declared hung.
   // The longest legal quiet stretch is the forced receiver hold-off.
   localparam int IDLE_LIMIT = 3000;
   // Cycles to watch for stray beats once the expected queue is empty. An
   // already aligned align item sends nothing but still runs the division.
   localparam int DRAIN_CYCLES = 150;
   localparam int RECEIVER_HOLD = 400;
   localparam int HOLD_AFTER_BEATS = 200;
   // Kind codes that the package leaves unnamed; the block must ignore them.
   localparam logic [2:0] KIND_UNUSED6 = 3'd6;
   localparam logic [2:0] KIND_UNUSED7 = 3'd7;
   // Marks a table row whose bytes come from the predictor.
   localparam int PREDICTED = -1;

   // One row of the directed table. Typed bytes are left-justified.
   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] value;
      logic [6:0]  modulus;
      int          typed_n;
      logic [79:0] typed_bytes;
   } stim_row_type;

   // One expected beat of the output stream.
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [62:0] pos;
   } stream_beat_type;

   localparam stim_row_type DIRECTED_ROWS [0:24] = '{
      // Aligned right after reset: nothing to pad.
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd8, 0, 80'h0},
      '{psvlq_pkg::KIND_BYTE, 64'hFFFF_FFFF_FFFF_FFAB, 7'd0, 1, 80'hAB00_0000_0000_0000_0000},
      '{psvlq_pkg::KIND_U32, 64'hDEAD_BEEF_0102_0304, 7'd0, 4, 80'h0102_0304_0000_0000_0000},
      '{psvlq_pkg::KIND_U64, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 8, 80'hFFFF_FFFF_FFFF_FFFF_0000},
      '{psvlq_pkg::KIND_U64, 64'd0, 7'd0, 8, 80'h0},
      // A zero varint is still one byte.
      '{psvlq_pkg::KIND_C32, 64'd0, 7'd0, 1, 80'h0},
      '{psvlq_pkg::KIND_C32, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 5, 80'h8FFF_FFFF_7F00_0000_0000},
      '{psvlq_pkg::KIND_C64, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 10, 80'h81FF_FFFF_FFFF_FFFF_FF7F},
      '{psvlq_pkg::KIND_C64, 64'd127, 7'd0, 1, 80'h7F00_0000_0000_0000_0000},
      '{psvlq_pkg::KIND_C64, 64'd128, 7'd0, 2, 80'h8100_0000_0000_0000_0000},
      '{psvlq_pkg::KIND_C64, 64'h8000_0000_0000_0000, 7'd0, 10, 80'h8180_8080_8080_8080_8000},
      '{KIND_UNUSED6, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 0, 80'h0},
      '{KIND_UNUSED7, 64'd0, 7'd0, 0, 80'h0},
      // Trivial moduli at an unaligned position.
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd0, 0, 80'h0},
      '{psvlq_pkg::KIND_ALIGN, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1, 0, 80'h0},
      // Oversized modulus clamps to the limit.
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd127, PREDICTED, 80'h0},
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd64, PREDICTED, 80'h0},
      '{psvlq_pkg::KIND_BYTE, 64'd0, 7'd0, 1, 80'h0},
      // One past a boundary: the longest padding run.
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd64, PREDICTED, 80'h0},
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd65, PREDICTED, 80'h0},
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd3, PREDICTED, 80'h0},
      '{psvlq_pkg::KIND_C32, 64'hFFFF_FFFF_0000_3FFF, 7'd0, PREDICTED, 80'h0},
      '{psvlq_pkg::KIND_U32, 64'hFFFF_FFFF_0000_0000, 7'd0, 4, 80'h0},
      '{psvlq_pkg::KIND_C64, 64'h0000_0000_0000_4000, 7'd0, PREDICTED, 80'h0},
      '{psvlq_pkg::KIND_ALIGN, 64'd0, 7'd7, PREDICTED, 80'h0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = psvlq_pkg::KIND_BYTE;
   logic [63:0] req_value = '0;
   logic [6:0]  req_align_modulus = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic [62:0] rsp_position;

   // Typed expectation of the item on the request port, driven with its payload.
   int          offered_typed_n = PREDICTED;
   logic [79:0] offered_typed_bytes = '0;

   stream_beat_type pending_beats[$];
   logic [63:0]     stream_count = '0;
   int              error_count = 0;
   int              beats_seen = 0;
   int              idle_cycles = 0;

   primitive_serializer_vlq #(
      .MAX_ALIGN(ALIGN_LIMIT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_value(req_value),
      .req_align_modulus(req_align_modulus),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last),
      .rsp_position(rsp_position)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Appends one stream byte and advances the running count, which wraps at 2^64.
   task automatic add_stream_byte(input logic [7:0] data, input logic last);
      stream_beat_type entry;
      stream_count = stream_count + 64'd1;
      entry.data = data;
      entry.last = last;
      entry.pos  = stream_count[62:0];
      pending_beats.push_back(entry);
   endtask

   // Computes the bytes one request item produces at the current stream count.
   task automatic encode_item(input logic [2:0] kind, input logic [63:0] value,
                              input logic [6:0] modulus);
      // Ten 7-bit groups, so the top group of a 64-bit value is in range.
      logic [69:0] source;
      logic [63:0] fill;
      logic [63:0] step_mod;
      int          groups;
      source = {6'd0, value};
      case (kind) inside
         psvlq_pkg::KIND_BYTE: begin
            add_stream_byte(value[7:0], 1'b1);
         end
         psvlq_pkg::KIND_U32: begin
            for (int i = 0; i < 4; i++)
               add_stream_byte(value[8*(3-i) +: 8], i == 3);
         end
         psvlq_pkg::KIND_U64: begin
            for (int i = 0; i < 8; i++)
               add_stream_byte(value[8*(7-i) +: 8], i == 7);
         end
         psvlq_pkg::KIND_C32, psvlq_pkg::KIND_C64: begin
            if (kind == psvlq_pkg::KIND_C32)
               source = {38'd0, value[31:0]};
            groups = 1;
            while (groups < 10 && (source >> (7 * groups)) != '0)
               groups++;
            // Most significant group first, continue bit on all but the last.
            for (int i = 0; i < groups; i++)
               add_stream_byte({i != groups - 1, source[7*(groups-1-i) +: 7]},
                               i == groups - 1);
         end
         psvlq_pkg::KIND_ALIGN: begin
            step_mod = (modulus > ALIGN_LIMIT) ? 64'(ALIGN_LIMIT) : 64'(modulus);
            if (step_mod >= 64'd2) begin
               fill = stream_count % step_mod;
               if (fill != 64'd0)
                  fill = step_mod - fill;
               for (logic [63:0] i = 0; i < fill; i++)
                  add_stream_byte(8'h00, i + 64'd1 == fill);
            end
         end
         default: begin
            // Unused kinds leave the stream untouched.
         end
      endcase
   endtask

   // Offers one item after a random gap and returns once it has been accepted.
   task automatic offer_item(input logic [2:0] kind, input logic [63:0] value,
                             input logic [6:0] modulus, input int typed_n,
                             input logic [79:0] typed_bytes);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         gap = 0;
      else if (pick < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_value           <= value;
      req_align_modulus   <= modulus;
      offered_typed_n     <= typed_n;
      offered_typed_bytes <= typed_bytes;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Monitor: records expectations for accepted request beats, checks every
   // accepted response beat, and runs the watchdog.
   always @(posedge clock) begin : monitor
      stream_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (offered_typed_n == PREDICTED) begin
               encode_item(req_kind, req_value, req_align_modulus);
            end else begin
               for (int i = 0; i < offered_typed_n; i++)
                  add_stream_byte(offered_typed_bytes[79-8*i -: 8],
                                  i == offered_typed_n - 1);
            end
         end
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (pending_beats.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat byte=%02h last=%0b position=%0d",
                        $time, rsp_out_byte, rsp_last, rsp_position);
            end else begin
               want = pending_beats.pop_front();
               if ({rsp_out_byte, rsp_last, rsp_position} !== want) begin
                  error_count++;
                  $display("%0t: mismatch expected byte=%02h last=%0b position=%0d",
                           $time, want.data, want.last, want.pos);
                  $display("%0t:          actual   byte=%02h last=%0b position=%0d",
                           $time, rsp_out_byte, rsp_last, rsp_position);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d beats still expected",
                     $time, pending_beats.size());
            $display("tb_primitive_serializer_vlq: FAIL");
            $finish;
         end
      end
   end

   // Receiver: ready runs and stalls of random length, with one long hold-off
   // while the sender keeps offering, so the block fills and stalls its input.
   initial begin : receiver
      int  run;
      int  gap;
      int  pick;
      bit  held;
      held = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         run  = (pick < 10) ? $urandom_range(60, 120) : $urandom_range(1, 12);
         pick = $urandom_range(0, 99);
         if (pick < 40)
            gap = 0;
         else if (pick < 92)
            gap = $urandom_range(1, 4);
         else
            gap = $urandom_range(10, 60);
         if (!held && beats_seen >= HOLD_AFTER_BEATS) begin
            held = 1'b1;
            gap  = RECEIVER_HOLD;
         end
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Sender and end of run.
   initial begin : sender
      int          counted;
      int          pick;
      logic [2:0]  kind;
      logic [63:0] value;
      logic [6:0]  modulus;
      counted = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r])
         offer_item(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].value,
                    DIRECTED_ROWS[r].modulus, DIRECTED_ROWS[r].typed_n,
                    DIRECTED_ROWS[r].typed_bytes);

      while (counted < RANDOM_ITEMS) begin
         value = {$urandom, $urandom};
         // Shift half the values down so every varint length shows up.
         if ($urandom_range(0, 1) != 0)
            value = value >> $urandom_range(1, 63);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            modulus = 7'($urandom_range(2, ALIGN_LIMIT));
         else if (pick < 85)
            modulus = 7'($urandom_range(0, 1));
         else
            modulus = 7'($urandom_range(ALIGN_LIMIT + 1, 127));
         pick = $urandom_range(0, 99);
         if (pick < 12)
            kind = psvlq_pkg::KIND_BYTE;
         else if (pick < 24)
            kind = psvlq_pkg::KIND_U32;
         else if (pick < 36)
            kind = psvlq_pkg::KIND_U64;
         else if (pick < 54)
            kind = psvlq_pkg::KIND_C32;
         else if (pick < 74)
            kind = psvlq_pkg::KIND_C64;
         else if (pick < 94)
            kind = psvlq_pkg::KIND_ALIGN;
         else if (pick < 97)
            kind = KIND_UNUSED6;
         else
            kind = KIND_UNUSED7;
         counted++;
         offer_item(kind, value, modulus, PREDICTED, 80'h0);
      end
      req_valid <= 1'b0;

      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_primitive_serializer_vlq: PASS");
      else
         $display("tb_primitive_serializer_vlq: FAIL");
      $finish;
   end

endmodule

@@ primitive_serializer_vlq.f @@
rtl/psvlq_pkg.sv
rtl/psvlq_rem.sv
rtl/primitive_serializer_vlq.sv
tb/tb_primitive_serializer_vlq.sv
